/* hw/rtl/dsc_pkg.sv */
// ----------------------------------------------------------------------------
// dsc_pkg - shared types for the deduplicating ordered set
// Item structs, operation and status codes, entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package dsc_pkg;

	localparam int ENTRY_W = 17;

	typedef enum logic [2:0] {
		OP_INSERT   = 3'd0,
		OP_ERASE_H  = 3'd1,
		OP_ERASE_I  = 3'd2,
		OP_CONTAINS = 3'd3,
		OP_CLEAR    = 3'd4,
		OP_READ     = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_BAD_INDEX = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_EVAL,
		FSM_APPLY
	} fsm_t;

	typedef struct packed {
		logic [2:0] operation;
		logic [6:0] item_handle;
		logic [4:0] loc_x;
		logic [4:0] loc_y;
		logic [6:0] position;
	} in_item_t;

	typedef struct packed {
		logic       found;
		logic [7:0] set_count;
		logic [6:0] entry_handle;
		logic [4:0] entry_x;
		logic [4:0] entry_y;
		logic [1:0] status;
	} out_item_t;

	// Command broadcast to every cell: evaluate enable, and write/shift for the apply cycle
	typedef struct packed {
		logic               eval_en;
		logic               write_en;
		logic               shift_en;
		logic [ENTRY_W-1:0] new_entry;
	} cell_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/dsc_cell.sv */
// ----------------------------------------------------------------------------
// dsc_cell - one slot of the set
// Holds one entry, compares it against the current item, and on erase
// takes its upper neighbor's entry to close the gap.
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_cell #(
	parameter int CNT_W = 8,
	parameter int IDX   = 0
) (
	input  wire logic                        clk,
	input  wire dsc_pkg::in_item_t           item,
	input  wire logic [CNT_W-1:0]            count,
	input  wire dsc_pkg::cell_cmd_t          cmd,
	input  wire logic                        shift_sel,
	input  wire logic [dsc_pkg::ENTRY_W-1:0] upper_entry,
	output logic [dsc_pkg::ENTRY_W-1:0]      entry_q,
	output logic                             hit_q,
	output logic [dsc_pkg::ENTRY_W-1:0]      rd_q
);

	localparam int WW = (CNT_W > 7) ? CNT_W : 7;

	logic slot_valid;
	logic pos_match;
	logic hit;

	assign slot_valid = CNT_W'(IDX) < count;
	assign pos_match  = WW'(item.position) == WW'(IDX);

	always_comb begin
		unique case (dsc_pkg::op_t'(item.operation)) inside
			dsc_pkg::OP_INSERT, dsc_pkg::OP_CONTAINS:
				hit = slot_valid && (entry_q[9:0] == {item.loc_x, item.loc_y});
			dsc_pkg::OP_ERASE_H:
				hit = slot_valid && (entry_q[16:10] == item.item_handle);
			dsc_pkg::OP_ERASE_I, dsc_pkg::OP_READ:
				hit = slot_valid && pos_match;
			default:
				hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.eval_en) begin
			hit_q <= hit;
			rd_q  <= hit ? entry_q : '0;
		end
		if (cmd.write_en && (CNT_W'(IDX) == count)) begin
			entry_q <= cmd.new_entry;
		end else if (cmd.shift_en && shift_sel) begin
			entry_q <= upper_entry;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/dsc_prefix_or.sv */
// ----------------------------------------------------------------------------
// dsc_prefix_or - log-depth prefix OR
// Bit i of the result is set when any hit at or below slot i is set.
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_prefix_or #(
	parameter int N = 128
) (
	input  wire logic [N-1:0] bits_in,
	output logic      [N-1:0] bits_out
);

	localparam int LV = (N > 1) ? $clog2(N) : 1;

	logic [N-1:0] lvl [LV+1];

	assign lvl[0] = bits_in;

	for (genvar l = 0; l < LV; l++) begin : g_lvl
		for (genvar i = 0; i < N; i++) begin : g_bit
			if (i >= (1 << l)) begin : g_or
				assign lvl[l+1][i] = lvl[l][i] | lvl[l][i-(1 << l)];
			end else begin : g_pass
				assign lvl[l+1][i] = lvl[l][i];
			end
		end
	end

	assign bits_out = lvl[LV];

endmodule

`default_nettype wire

/* hw/rtl/dedup_set_with_compaction.sv */
// ----------------------------------------------------------------------------
// dedup_set_with_compaction - bounded ordered set with duplicate rejection
// Insert-ordered entries of (handle, x, y) kept in a row of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//  - in_valid/in_ready/in_item carry one command item: insert, erase by
//    handle, erase at index, contains, clear, or read at index.
//  - out_valid/out_ready/out_item return exactly one result item per
//    command, in order, with the entry count after the operation.
//  - Each item passes through an evaluate cycle in which every
//    slot compares its entry against the key in parallel and registers a
//    hit, and an apply cycle that merges the hits (prefix OR for the
//    erase point, OR reduction for found and read data) and updates the
//    slots. The result is written to the output register at commit,
//    which raises out_valid.
//  - The next item is taken in the same cycle the previous one
//    commits, while the previous result sits in the output register.
//  - Erase shifts every slot above the removed one down by one during
//    the apply cycle; no sweep is needed.
//  - If out_ready is low with a result still waiting, the apply step holds
//    (nothing is written) until the output register frees.
//  - Reset empties the set and drops any pending result. Slot contents
//    are not cleared; only slots below the count are ever looked at.
// ----------------------------------------------------------------------------
`default_nettype none

module dedup_set_with_compaction #(
	parameter int CAPACITY = 128
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire dsc_pkg::in_item_t   in_item,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output dsc_pkg::out_item_t       out_item
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int WW    = (CNT_W > 7) ? CNT_W : 7;
	localparam int EW    = dsc_pkg::ENTRY_W;

	dsc_pkg::fsm_t      state_q, state_nxt;
	dsc_pkg::in_item_t  item_q;
	dsc_pkg::out_item_t out_q, res;
	dsc_pkg::cell_cmd_t cmd;
	logic               out_valid_q;
	logic [CNT_W-1:0]   count_q, count_nxt;

	logic               accept, commit, eval_en;
	logic               any_hit, pos_ok, full;
	logic               write_req, shift_req;
	logic [EW-1:0]      rd_or;

	logic [CAPACITY-1:0] hit_vec, shift_vec;
	logic [EW-1:0]       entry_cell [CAPACITY];
	logic [EW-1:0]       rd_cell    [CAPACITY];

	// ---------------- sequencer ----------------
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			dsc_pkg::FSM_IDLE:  if (accept) state_nxt = dsc_pkg::FSM_EVAL;
			dsc_pkg::FSM_EVAL:  state_nxt = dsc_pkg::FSM_APPLY;
			dsc_pkg::FSM_APPLY: begin
				if (commit) state_nxt = accept ? dsc_pkg::FSM_EVAL : dsc_pkg::FSM_IDLE;
			end
			default:            state_nxt = dsc_pkg::FSM_IDLE;
		endcase
	end

	always_comb begin
		commit   = (state_q == dsc_pkg::FSM_APPLY) && (!out_valid_q || out_ready);
		eval_en  = (state_q == dsc_pkg::FSM_EVAL);
		in_ready = (state_q == dsc_pkg::FSM_IDLE) || commit;
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsc_pkg::FSM_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_item;
		end
	end

	// ---------------- slot row ----------------
	dsc_prefix_or #(.N(CAPACITY)) u_prefix (
		.bits_in  (hit_vec),
		.bits_out (shift_vec)
	);

	assign cmd.eval_en   = eval_en;
	assign cmd.write_en  = commit && write_req;
	assign cmd.shift_en  = commit && shift_req;
	assign cmd.new_entry = {item_q.item_handle, item_q.loc_x, item_q.loc_y};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [EW-1:0] upper;
		if (i == CAPACITY - 1) begin : g_top
			assign upper = '0;
		end else begin : g_mid
			assign upper = entry_cell[i+1];
		end

		dsc_cell #(.CNT_W(CNT_W), .IDX(i)) u_cell (
			.clk         (clk),
			.item        (item_q),
			.count       (count_q),
			.cmd         (cmd),
			.shift_sel   (shift_vec[i]),
			.upper_entry (upper),
			.entry_q     (entry_cell[i]),
			.hit_q       (hit_vec[i]),
			.rd_q        (rd_cell[i])
		);
	end

	// read data: for a read, at most one slot has a nonzero gated value
	always_comb begin
		rd_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_or = rd_or | rd_cell[i];
		end
	end

	// ---------------- apply decode ----------------
	assign any_hit = |hit_vec;
	assign pos_ok  = WW'(item_q.position) < WW'(count_q);
	assign full    = count_q == CNT_W'(CAPACITY);

	always_comb begin
		res        = '0;
		count_nxt  = count_q;
		write_req  = 1'b0;
		shift_req  = 1'b0;
		res.status = dsc_pkg::ST_OK;
		unique case (item_q.operation)
			dsc_pkg::OP_INSERT: begin
				res.found = any_hit;
				if (!any_hit) begin
					if (full) begin
						res.status = dsc_pkg::ST_FULL;
					end else begin
						write_req = 1'b1;
						count_nxt = count_q + CNT_W'(1);
					end
				end
			end
			dsc_pkg::OP_ERASE_H: begin
				res.found = any_hit;
				if (any_hit) begin
					shift_req = 1'b1;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			dsc_pkg::OP_ERASE_I: begin
				if (pos_ok) begin
					shift_req = 1'b1;
					count_nxt = count_q - CNT_W'(1);
				end else begin
					res.status = dsc_pkg::ST_BAD_INDEX;
				end
			end
			dsc_pkg::OP_CONTAINS: begin
				res.found = any_hit;
			end
			dsc_pkg::OP_CLEAR: begin
				count_nxt = '0;
			end
			dsc_pkg::OP_READ: begin
				if (pos_ok) begin
					res.entry_handle = rd_or[16:10];
					res.entry_x      = rd_or[9:5];
					res.entry_y      = rd_or[4:0];
				end else begin
					res.status = dsc_pkg::ST_BAD_INDEX;
				end
			end
			default: ;
		endcase
		res.set_count = 8'(count_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire
